// ----- src/nearest_key_binary_search_macros.svh -----
// Assertion helpers for the nearest-key search block.
// Both expect clk and rst_n in scope; checks are off while in reset.
`ifndef NEAREST_KEY_BINARY_SEARCH_MACROS_SVH
`define NEAREST_KEY_BINARY_SEARCH_MACROS_SVH

// same-cycle implication
`define NKBS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NKBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/nkbs_pkg.sv -----
package nkbs_pkg;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        point_key;
    logic signed [31:0] point_value;
    logic [31:0]        query_key;
  } in_t;

  typedef struct packed {
    logic               found;
    logic               exact;
    logic [31:0]        near_key;
    logic signed [31:0] near_value;
  } out_t;

  function automatic logic [31:0] key_dist(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ab;
    logic [31:0] ba;
    ab = a - b;
    ba = b - a;
    return (a >= b) ? ab : ba;
  endfunction

endpackage

// ----- src/nkbs_store.sv -----
// Point table: one write port, one read port with registered read data.
module nkbs_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [31:0]        wr_key,
  input  logic signed [31:0] wr_value,
  input  logic [AW-1:0]      rd_addr,
  output logic [31:0]        rd_key,
  output logic signed [31:0] rd_value
);

  logic [31:0]        key_mem   [DEPTH];
  logic signed [31:0] value_mem [DEPTH];
  logic [31:0]        rd_key_r;
  logic signed [31:0] rd_value_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]   <= wr_key;
      value_mem[wr_addr] <= wr_value;
    end
    rd_key_r   <= key_mem[rd_addr];
    rd_value_r <= value_mem[rd_addr];
  end

  assign rd_key   = rd_key_r;
  assign rd_value = rd_value_r;

endmodule

// ----- src/nearest_key_binary_search.sv -----
// Clear and append items are accepted back to back. A query stalls the input while
// it runs: P probes at one table read per cycle (P <= ceil(log2(count))), two reads
// to pick between the final pair, then the output load; an exact hit at a probe skips
// the pick. Two-point tables skip the probes, one-point tables read their entry, empty
// ones go straight to the output load, which waits while the output is stalled.
// Reset (rst_n low, synchronous) empties the table and idles the sequencer.
module nearest_key_binary_search #(
  parameter int DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  nkbs_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output nkbs_pkg::out_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SINGLE  = 3'd1;
  localparam logic [2:0] S_PROBE   = 3'd2;
  localparam logic [2:0] S_PICK_LO = 3'd3;
  localparam logic [2:0] S_PICK_HI = 3'd4;
  localparam logic [2:0] S_OUT     = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [31:0]         q_r, q_nxt;
  logic [31:0]         lo_key_r, lo_key_nxt;
  logic signed [31:0]  lo_value_r, lo_value_nxt;
  logic [31:0]         dist_lo_r, dist_lo_nxt;
  nkbs_pkg::out_t      res_r, res_nxt;
  nkbs_pkg::out_t      out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                in_acc;
  logic                wr_en;
  logic [AW-1:0]       rd_addr;
  logic [31:0]         rd_key;
  logic signed [31:0]  rd_value;
  logic [CW-1:0]       cnt_m1;
  logic [AW:0]         mid_sum;
  logic [AW-1:0]       span;
  logic [31:0]         dist_hi;
  logic                out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && (in_data.func == nkbs_pkg::FUNC_APPEND)
                    && (count_r < CW'(DEPTH));
  assign cnt_m1   = count_r - CW'(1);
  assign out_free = !out_valid_r || !out_stall;
  assign dist_hi  = nkbs_pkg::key_dist(rd_key, q_r);

  nkbs_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (count_r[AW-1:0]),
    .wr_key   (in_data.point_key),
    .wr_value (in_data.point_value),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    q_nxt         = q_r;
    lo_key_nxt    = lo_key_r;
    lo_value_nxt  = lo_value_r;
    dist_lo_nxt   = dist_lo_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_addr       = '0;
    mid_sum       = '0;
    span          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.func)
            nkbs_pkg::FUNC_CLEAR: begin
              count_nxt = '0;
            end
            nkbs_pkg::FUNC_APPEND: begin
              if (wr_en) begin
                count_nxt = count_r + CW'(1);
              end
            end
            nkbs_pkg::FUNC_QUERY: begin
              q_nxt = in_data.query_key;
              if (count_r == '0) begin
                res_nxt   = '0;
                state_nxt = S_OUT;
              end else if (count_r == CW'(1)) begin
                state_nxt = S_SINGLE;
              end else if (count_r == CW'(2)) begin
                lo_nxt    = '0;
                hi_nxt    = AW'(1);
                state_nxt = S_PICK_LO;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = cnt_m1[AW-1:0];
                mid_nxt   = cnt_m1[AW-1:0] >> 1;
                rd_addr   = mid_nxt;
                state_nxt = S_PROBE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SINGLE: begin
        res_nxt.found      = 1'b1;
        res_nxt.exact      = (rd_key == q_r);
        res_nxt.near_key   = rd_key;
        res_nxt.near_value = rd_value;
        state_nxt          = S_OUT;
      end

      S_PROBE: begin
        // rd_key holds key_mem[mid_r]
        if (rd_key == q_r) begin
          res_nxt.found      = 1'b1;
          res_nxt.exact      = 1'b1;
          res_nxt.near_key   = rd_key;
          res_nxt.near_value = rd_value;
          state_nxt          = S_OUT;
        end else begin
          if (q_r > rd_key) begin
            lo_nxt = mid_r;
          end else begin
            hi_nxt = mid_r;
          end
          span = hi_nxt - lo_nxt;
          if (span <= AW'(1)) begin
            rd_addr   = lo_nxt;
            state_nxt = S_PICK_LO;
          end else begin
            mid_sum   = {1'b0, lo_nxt} + {1'b0, hi_nxt};
            mid_nxt   = mid_sum[AW:1];
            rd_addr   = mid_nxt;
          end
        end
      end

      S_PICK_LO: begin
        lo_key_nxt   = rd_key;
        lo_value_nxt = rd_value;
        dist_lo_nxt  = nkbs_pkg::key_dist(rd_key, q_r);
        rd_addr      = hi_r;
        state_nxt    = S_PICK_HI;
      end

      S_PICK_HI: begin
        // higher index wins a tie
        res_nxt.found = 1'b1;
        if (dist_hi <= dist_lo_r) begin
          res_nxt.exact      = (rd_key == q_r);
          res_nxt.near_key   = rd_key;
          res_nxt.near_value = rd_value;
        end else begin
          res_nxt.exact      = (lo_key_r == q_r);
          res_nxt.near_key   = lo_key_r;
          res_nxt.near_value = lo_value_r;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    q_r        <= q_nxt;
    lo_key_r   <= lo_key_nxt;
    lo_value_r <= lo_value_nxt;
    dist_lo_r  <= dist_lo_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- src/nkbs_checker.sv -----
`include "nearest_key_binary_search_macros.svh"

module nkbs_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input nkbs_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input nkbs_pkg::out_t out_data
);

  logic q_acc;
  logic res_zero;

  assign q_acc    = in_valid && !in_stall && (in_data.func == nkbs_pkg::FUNC_QUERY);
  assign res_zero = !out_data.exact && (out_data.near_key == 32'd0)
                    && (out_data.near_value == 32'sd0);

  `NKBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled")
  `NKBS_ASSERT_NEXT(a_query_busy, q_acc, in_stall, "query item did not stall the input")
  `NKBS_ASSERT_IMPL(a_not_found_zero, out_valid && !out_data.found, res_zero, "empty not zero")
  `NKBS_ASSERT_IMPL(a_exact_found, out_valid && out_data.exact, out_data.found, "exact, no found")

endmodule

bind nearest_key_binary_search nkbs_checker u_nkbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- dv/tb_top.sv -----
module tb_top;

  localparam int TABLE_DEPTH = 1024;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  nkbs_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  nkbs_pkg::out_t out_data;

  nearest_key_binary_search #(.DEPTH(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // table shadow
  logic [31:0] shadow_key   [TABLE_DEPTH];
  logic [31:0] shadow_value [TABLE_DEPTH];
  int unsigned shadow_count;

  nkbs_pkg::in_t  pending_items [$];
  nkbs_pkg::out_t nearest_expected [$];
  int   item_count;
  int   fail_count;
  int   send_idle_pct;
  int   recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  function automatic logic [31:0] tick_gap(logic [31:0] a, logic [31:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // higher index wins unless strictly farther
  function automatic int unsigned closer_index(int unsigned lo, int unsigned hi,
                                               logic [31:0] q);
    if (tick_gap(shadow_key[hi], q) <= tick_gap(shadow_key[lo], q))
      return hi;
    return lo;
  endfunction

  function automatic int unsigned nearest_index(logic [31:0] q);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    if (shadow_count == 1) return 0;
    if (shadow_count == 2) return closer_index(0, 1, q);
    lo = 0;
    hi = shadow_count - 1;
    while (hi > lo) begin
      mid = (lo + hi) >> 1;
      if (q == shadow_key[mid]) return mid;
      if (q > shadow_key[mid]) lo = mid;
      else hi = mid;
      if (hi - lo <= 1) return closer_index(lo, hi, q);
    end
    return lo;
  endfunction

  task automatic update_table(nkbs_pkg::in_t it);
    nkbs_pkg::out_t want;
    int unsigned idx;
    case (it.func)
      nkbs_pkg::FUNC_CLEAR: shadow_count = 0;
      nkbs_pkg::FUNC_APPEND: begin
        if (shadow_count < TABLE_DEPTH) begin
          shadow_key[shadow_count]   = it.point_key;
          shadow_value[shadow_count] = it.point_value;
          shadow_count++;
        end
      end
      nkbs_pkg::FUNC_QUERY: begin
        want = '0;
        if (shadow_count != 0) begin
          idx = nearest_index(it.query_key);
          if (idx >= shadow_count) idx = shadow_count - 1;
          want.found      = 1'b1;
          want.exact      = (shadow_key[idx] == it.query_key);
          want.near_key   = shadow_key[idx];
          want.near_value = shadow_value[idx];
        end
        nearest_expected.push_back(want);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) update_table(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    nkbs_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (nearest_expected.size() == 0) begin
        report_mismatch("unexpected result, near_key", out_data.near_key, '0);
      end else begin
        want = nearest_expected.pop_front();
        if (out_data.found !== want.found)
          report_mismatch("found", out_data.found, want.found);
        if (out_data.exact !== want.exact)
          report_mismatch("exact", out_data.exact, want.exact);
        if (out_data.near_key !== want.near_key)
          report_mismatch("near_key", out_data.near_key, want.near_key);
        if (out_data.near_value !== want.near_value)
          report_mismatch("near_value", out_data.near_value, want.near_value);
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // unused fields carry random bits
  function automatic nkbs_pkg::in_t make_item(logic [1:0] f, logic [31:0] pk,
                                              logic [31:0] pv, logic [31:0] qk);
    nkbs_pkg::in_t it;
    it.func        = f;
    it.point_key   = pk;
    it.point_value = pv;
    it.query_key   = qk;
    return it;
  endfunction

  task automatic push_item(nkbs_pkg::in_t it);
    pending_items.push_back(it);
    if (it.func != FUNC_UNUSED) item_count++;
  endtask

  task automatic push_append(logic [31:0] k, logic [31:0] v);
    push_item(make_item(nkbs_pkg::FUNC_APPEND, k, v, $urandom));
  endtask

  task automatic push_query(logic [31:0] q);
    push_item(make_item(nkbs_pkg::FUNC_QUERY, $urandom, $urandom, q));
  endtask

  task automatic push_clear();
    push_item(make_item(nkbs_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom));
  endtask

  // an optional clear, a load of points, then queries aimed at, around and between them or at random keys
  task automatic point_run(int n_points, bit do_clear, bit ordered);
    logic [31:0] keys [$];
    logic [63:0] k;
    logic [31:0] cap;
    logic [31:0] q;
    logic [31:0] a;
    logic [31:0] b;
    int n_q;
    int j;
    if (do_clear) push_clear();
    case ($urandom_range(2))
      0: cap = 32'd4;
      1: cap = 32'd1000;
      default: cap = 32'hFFFF_FFFF / (n_points + 1);
    endcase
    k = ($urandom_range(1) == 0) ? 64'd0 : 64'($urandom >> $urandom_range(31, 4));
    for (int i = 0; i < n_points; i++) begin
      if (ordered) begin
        k = k + 64'($urandom_range(cap, 0));
        if (k > 64'hFFFF_FFFF) k = 64'hFFFF_FFFF;
        keys.push_back(k[31:0]);
      end else begin
        keys.push_back($urandom);
      end
      push_append(keys[keys.size() - 1], $urandom);
    end
    n_q = $urandom_range(10, 1);
    for (int i = 0; i < n_q; i++) begin
      q = $urandom;
      if (keys.size() != 0) begin
        j = $urandom_range(keys.size() - 1, 0);
        case ($urandom_range(5))
          0: q = keys[j];
          1: q = keys[j] + 32'($urandom_range(4)) - 32'd2;
          2: begin
            if (keys.size() >= 2) begin
              j = $urandom_range(keys.size() - 2, 0);
              a = keys[j];
              b = keys[j + 1];
              q = a + (b - a) / 2;
            end
          end
          5: q = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
          default: ;
        endcase
      end
      push_query(q);
    end
  endtask

  task automatic noise_burst(int n);
    for (int i = 0; i < n; i++)
      push_item(make_item(2'($urandom_range(3)), $urandom, $urandom, $urandom));
  endtask

  task automatic random_phase(int target);
    int start;
    int sel;
    start = item_count;
    while (item_count - start < target) begin
      sel = $urandom_range(99);
      if (sel < 75)
        point_run(($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(16, 0),
                  $urandom_range(4) != 0, 1'b1);
      else if (sel < 87)
        point_run($urandom_range(12, 2), $urandom_range(1) != 0, 1'b0);
      else
        noise_burst($urandom_range(6, 1));
    end
  endtask

  task automatic wait_drain();
    while (pending_items.size() != 0 || in_valid || nearest_expected.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    shadow_count  = 0;
    item_count    = 0;
    fail_count    = 0;
    send_idle_pct = 7;
    recv_idle_pct = 45;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, unused code, one, two and four point tables, ties, extremes, clear
    push_query($urandom);
    push_item(make_item(FUNC_UNUSED, $urandom, $urandom, $urandom));
    push_append(32'h0, 32'h8000_0000);
    push_query(32'h0);
    push_query(32'hFFFF_FFFF);
    push_append(32'd100, 32'h7FFF_FFFF);
    push_query(32'd50);
    push_query(32'd49);
    push_query(32'hFFFF_FFFF);
    push_append(32'd200, 32'd5);
    push_append(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_query(32'd150);
    push_query(32'd100);
    push_query(32'hFFFF_FFFF);
    push_query(32'h0);
    push_clear();
    push_query(32'd7);
    // keys out of order
    push_append(32'd500, $urandom);
    push_append(32'd10, $urandom);
    push_append(32'd300, $urandom);
    push_query(32'd10);
    push_query(32'd400);
    push_item(make_item(FUNC_UNUSED, $urandom, $urandom, $urandom));
    push_query(32'd500);

    random_phase(290);
    wait_drain();

    send_idle_pct = 45;
    recv_idle_pct = 7;
    random_phase(290);
    wait_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(290);
    wait_drain();

    repeat (40) @(posedge clk);
    if (nearest_expected.size() != 0)
      report_mismatch("results never arrived, count", '0, nearest_expected.size());
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Verification failed");
    $finish;
  end

endmodule
